// ===== hw/rtl/rpd_pkg.sv =====
// Shared types and constants for the reply packet deframer.
package rpd_pkg;

	// Offset of the last header/address byte that is skipped.
	localparam logic [2:0] HdrLastOfs = 3'd5;
	// The length field also counts the confirm code and the two checksum bytes.
	localparam logic [15:0] FixedLenPart = 16'd3;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SKIP,
		PH_IDENT,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_CONFIRM,
		PH_PARAMS,
		PH_CK_HI,
		PH_CK_LO,
		PH_DONE
	} phase_t;

	typedef enum logic {
		KIND_PARAM = 1'b0,
		KIND_END   = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] index;
		logic [7:0]  pbyte;
		logic [7:0]  ident;
		logic [7:0]  confirm;
		logic [15:0] length;
		logic        ok;
	} result_t;

endpackage

// ===== hw/rtl/rpd_core.sv =====
// Packet parser state machine with checksum accumulation, one word per cycle while accept is high.
module rpd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       rx_byte,
	input  logic             start_of_packet,
	output logic             res_valid,
	output rpd_pkg::result_t res
);
	import rpd_pkg::*;

	phase_t      phase_q, phase_n;
	logic [2:0]  skip_cnt_q, skip_cnt_n;
	logic [15:0] left_q, left_n;
	logic [15:0] pos_q, pos_n;
	logic [15:0] sum_q, sum_n;
	logic [7:0]  ident_q, ident_n;
	logic [15:0] len_q, len_n;
	logic [7:0]  confirm_q, confirm_n;
	logic [7:0]  ckhi_q, ckhi_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			skip_cnt_q <= '0;
			left_q     <= '0;
			pos_q      <= '0;
			sum_q      <= '0;
			ident_q    <= '0;
			len_q      <= '0;
			confirm_q  <= '0;
			ckhi_q     <= '0;
		end else if (accept) begin
			phase_q    <= phase_n;
			skip_cnt_q <= skip_cnt_n;
			left_q     <= left_n;
			pos_q      <= pos_n;
			sum_q      <= sum_n;
			ident_q    <= ident_n;
			len_q      <= len_n;
			confirm_q  <= confirm_n;
			ckhi_q     <= ckhi_n;
		end
	end

	always_comb begin
		phase_t      ph;
		logic [15:0] len_full;

		ph         = phase_q;
		skip_cnt_n = skip_cnt_q;
		left_n     = left_q;
		pos_n      = pos_q;
		sum_n      = sum_q;
		ident_n    = ident_q;
		len_n      = len_q;
		confirm_n  = confirm_q;
		ckhi_n     = ckhi_q;
		len_full   = {len_q[15:8], rx_byte};

		// A flagged word restarts the packet, dropping any partial one.
		if (start_of_packet) begin
			ph         = PH_SKIP;
			skip_cnt_n = '0;
			left_n     = '0;
			pos_n      = '0;
			sum_n      = '0;
			ident_n    = '0;
			len_n      = '0;
			confirm_n  = '0;
			ckhi_n     = '0;
		end

		phase_n   = ph;
		res_valid = 1'b0;
		res       = '{kind: KIND_PARAM, index: pos_n, pbyte: rx_byte, ident: ident_n,
		              confirm: confirm_n, length: len_n, ok: 1'b0};

		unique case (ph)
			PH_SKIP: begin
				if (skip_cnt_n >= HdrLastOfs) begin
					phase_n = PH_IDENT;
				end else begin
					skip_cnt_n = skip_cnt_n + 3'd1;
				end
			end
			PH_IDENT: begin
				ident_n = rx_byte;
				phase_n = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_n   = {rx_byte, 8'h00};
				phase_n = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_n   = len_full;
				left_n  = (len_full >= FixedLenPart) ? len_full - FixedLenPart : 16'd0;
				phase_n = PH_CONFIRM;
			end
			PH_CONFIRM: begin
				// The sum is seeded with the header fields so the end check is one compare.
				confirm_n = rx_byte;
				pos_n     = '0;
				sum_n     = len_q + {8'h00, ident_q} + {8'h00, rx_byte};
				phase_n   = (left_q != 16'd0) ? PH_PARAMS : PH_CK_HI;
			end
			PH_PARAMS: begin
				res_valid = 1'b1;
				sum_n     = sum_q + {8'h00, rx_byte};
				pos_n     = pos_q + 16'd1;
				left_n    = left_q - 16'd1;
				if (left_q == 16'd1) begin
					phase_n = PH_CK_HI;
				end
			end
			PH_CK_HI: begin
				ckhi_n  = rx_byte;
				phase_n = PH_CK_LO;
			end
			PH_CK_LO: begin
				res_valid = 1'b1;
				res.kind  = KIND_END;
				res.index = '0;
				res.pbyte = '0;
				res.ok    = ({ckhi_q, rx_byte} == sum_q);
				phase_n   = PH_DONE;
			end
			default: begin
				phase_n = ph;
			end
		endcase
	end

endmodule

// ===== hw/rtl/rpd_outq.sv =====
// Two-entry result queue that decouples the parser from output stalls.
module rpd_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rpd_pkg::result_t push_data,
	output logic             not_full,
	output logic             out_valid,
	input  logic             out_ready,
	output rpd_pkg::result_t out_data
);
	import rpd_pkg::*;

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign not_full  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== hw/rtl/reply_packet_deframer.sv =====
// Reply packet deframer: takes one packet word per cycle while in_ready is high, and
// emits parameter words and a checksum verdict. Each result is registered in a two-entry
// result queue that sits between the parser and the output, so input keeps flowing
// while one result waits; in_ready drops only when both queue entries are occupied.
module reply_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        start_of_packet,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [15:0] param_index,
	output logic [7:0]  param_byte,
	output logic [7:0]  packet_ident,
	output logic [7:0]  confirm_value,
	output logic [15:0] length_field,
	output logic        checksum_ok
);
	import rpd_pkg::*;

	logic    accept;
	logic    res_valid;
	result_t res;
	result_t out_data;

	assign accept = in_valid && in_ready;

	rpd_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.rx_byte        (rx_byte),
		.start_of_packet(start_of_packet),
		.res_valid      (res_valid),
		.res            (res)
	);

	rpd_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && res_valid),
		.push_data(res),
		.not_full (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	assign result_kind   = out_data.kind;
	assign param_index   = out_data.index;
	assign param_byte    = out_data.pbyte;
	assign packet_ident  = out_data.ident;
	assign confirm_value = out_data.confirm;
	assign length_field  = out_data.length;
	assign checksum_ok   = out_data.ok;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the reply packet deframer with a table-driven directed part.
`timescale 1ns / 1ps

module tb;
	import rpd_pkg::*;

	localparam int ResetCycles = 9;
	localparam int ItemsPerPhase = 313;
	localparam int StuckLimit = 2000;
	localparam int TailCycles = 20;
	localparam int ReportLimit = 10;

	typedef struct {
		logic [7:0] data;
		logic       sop;
		bit         typed;
		result_t    want;
	} word_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        start_of_packet = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        result_kind;
	logic [15:0] param_index;
	logic [7:0]  param_byte;
	logic [7:0]  packet_ident;
	logic [7:0]  confirm_value;
	logic [15:0] length_field;
	logic        checksum_ok;

	word_row_t   word_queue[$];
	result_t     pending_results[$];
	result_t     got_res;
	result_t     want_res;
	int unsigned mismatch_count = 0;
	int unsigned stuck_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned idle_plan[4] = '{0, 72, 0, 33};
	int unsigned stall_plan[4] = '{0, 0, 72, 33};
	bit          stim_done = 1'b0;
	bit          timed_out;

	// Predictor state, mirroring the parser's registers.
	phase_t      cur_phase = PH_IDLE;
	logic [2:0]  skip_count = '0;
	logic [15:0] params_remaining = '0;
	logic [15:0] param_pos = '0;
	logic [15:0] param_sum = '0;
	logic [7:0]  ident_q = '0;
	logic [15:0] length_q = '0;
	logic [7:0]  confirm_q = '0;
	logic [7:0]  ck_high = '0;

	reply_packet_deframer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.start_of_packet(start_of_packet),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.param_index(param_index),
		.param_byte(param_byte),
		.packet_ident(packet_ident),
		.confirm_value(confirm_value),
		.length_field(length_field),
		.checksum_ok(checksum_ok)
	);

	always #5 clk = ~clk;

	// Advances the predictor by one word; returns 1 when the word yields a result.
	function automatic bit deframe_step(input logic [7:0] b, input logic sop,
			output result_t res);
		logic [15:0] sum;
		res = '0;
		deframe_step = 1'b0;
		if (sop) begin
			cur_phase = PH_SKIP;
			skip_count = '0;
			params_remaining = '0;
			param_pos = '0;
			param_sum = '0;
			ident_q = '0;
			length_q = '0;
			confirm_q = '0;
			ck_high = '0;
		end
		case (cur_phase)
			PH_SKIP: begin
				if (skip_count >= HdrLastOfs)
					cur_phase = PH_IDENT;
				else
					skip_count = skip_count + 3'd1;
			end
			PH_IDENT: begin
				ident_q = b;
				cur_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				length_q = {b, 8'h00};
				cur_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				length_q = {length_q[15:8], b};
				params_remaining = (length_q >= FixedLenPart) ? length_q - FixedLenPart : 16'd0;
				cur_phase = PH_CONFIRM;
			end
			PH_CONFIRM: begin
				confirm_q = b;
				param_pos = '0;
				param_sum = '0;
				cur_phase = (params_remaining != 16'd0) ? PH_PARAMS : PH_CK_HI;
			end
			PH_PARAMS: begin
				res = '{kind: KIND_PARAM, index: param_pos, pbyte: b, ident: ident_q,
					confirm: confirm_q, length: length_q, ok: 1'b0};
				deframe_step = 1'b1;
				param_sum = param_sum + {8'h00, b};
				param_pos = param_pos + 16'd1;
				params_remaining = params_remaining - 16'd1;
				if (params_remaining == 16'd0)
					cur_phase = PH_CK_HI;
			end
			PH_CK_HI: begin
				ck_high = b;
				cur_phase = PH_CK_LO;
			end
			PH_CK_LO: begin
				sum = param_sum + {8'h00, ident_q} + length_q + {8'h00, confirm_q};
				res = '{kind: KIND_END, index: 16'd0, pbyte: 8'h00, ident: ident_q,
					confirm: confirm_q, length: length_q, ok: ({ck_high, b} == sum)};
				deframe_step = 1'b1;
				cur_phase = PH_DONE;
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_word(input logic [7:0] data, input logic sop);
		word_queue.push_back('{data: data, sop: sop, typed: 1'b0, want: '0});
	endfunction

	function automatic void queue_word_result(input logic [7:0] data, input logic sop,
			input kind_t kind, input logic [15:0] index, input logic [7:0] pbyte,
			input logic [7:0] ident, input logic [7:0] confirm, input logic [15:0] length,
			input logic ok);
		word_queue.push_back('{data: data, sop: sop, typed: 1'b1,
			want: '{kind: kind, index: index, pbyte: pbyte, ident: ident,
			confirm: confirm, length: length, ok: ok}});
	endfunction

	task automatic load_directed_rows();
		// A word before any start is dropped.
		queue_word(8'hA5, 1'b0);
		// Short length of one: no parameters, checksum right after the confirm code.
		queue_word(8'hEF, 1'b1);
		queue_word(8'h01, 1'b0);
		repeat (4) queue_word(8'hFF, 1'b0);
		queue_word(8'hFF, 1'b0);
		queue_word(8'h00, 1'b0);
		queue_word(8'h01, 1'b0);
		queue_word(8'hFF, 1'b0);
		queue_word(8'h01, 1'b0);
		queue_word_result(8'hFF, 1'b0, KIND_END, 16'd0, 8'h00, 8'hFF, 8'hFF, 16'h0001, 1'b1);
		// Trailing word after the checksum is ignored.
		queue_word(8'h00, 1'b0);
		// This packet is cut short by a new start in its header.
		queue_word(8'hEF, 1'b1);
		queue_word(8'hEF, 1'b1);
		queue_word(8'h01, 1'b0);
		repeat (4) queue_word(8'h00, 1'b0);
		queue_word(8'h00, 1'b0);
		queue_word(8'h00, 1'b0);
		queue_word(8'h04, 1'b0);
		queue_word(8'h00, 1'b0);
		queue_word_result(8'hFF, 1'b0, KIND_PARAM, 16'd0, 8'hFF, 8'h00, 8'h00, 16'h0004, 1'b0);
		queue_word(8'hFF, 1'b0);
		// Received checksum 0xFFFF against a computed 0x0103.
		queue_word_result(8'hFF, 1'b0, KIND_END, 16'd0, 8'h00, 8'h00, 8'h00, 16'h0004, 1'b0);
	endtask

	// Queues one packet with random content; most are well formed, some are cut off
	// by the next start, and a few are stray words outside any packet.
	task automatic add_random_packet(inout int unsigned counted);
		logic [7:0]  pkt[$];
		logic [7:0]  ident;
		logic [7:0]  confirm;
		logic [7:0]  pb;
		logic [15:0] len;
		logic [15:0] sum;
		logic [15:0] ck;
		int unsigned roll;
		int unsigned n_params;
		int unsigned keep;
		bit          aborted;
		roll = $urandom_range(99);
		if (roll < 6) begin
			repeat ($urandom_range(1, 3)) queue_word(8'($urandom_range(255)), 1'b0);
			return;
		end
		aborted = (roll < 16);
		if (roll < 9)
			len = 16'hFFFF;
		else if (aborted)
			len = 16'($urandom_range(65535));
		else if (roll < 28)
			len = 16'($urandom_range(2));
		else if (roll < 90)
			len = 16'($urandom_range(3, 12));
		else
			len = 16'($urandom_range(13, 40));
		n_params = (len >= 16'd3) ? int'(len) - 3 : 0;
		if (aborted && n_params > 8)
			n_params = 8;
		ident = 8'($urandom_range(255));
		confirm = 8'($urandom_range(255));
		sum = {8'h00, ident} + len + {8'h00, confirm};
		repeat (6) pkt.push_back(8'($urandom_range(255)));
		pkt.push_back(ident);
		pkt.push_back(len[15:8]);
		pkt.push_back(len[7:0]);
		pkt.push_back(confirm);
		repeat (n_params) begin
			pb = 8'($urandom_range(255));
			sum = sum + {8'h00, pb};
			pkt.push_back(pb);
		end
		ck = ($urandom_range(99) < 75) ? sum : 16'($urandom_range(65535));
		pkt.push_back(ck[15:8]);
		pkt.push_back(ck[7:0]);
		keep = aborted ? $urandom_range(1, pkt.size() - 2) : pkt.size();
		for (int i = 0; i < keep; i++)
			queue_word(pkt[i], i == 0);
		counted += keep;
		if (!aborted && $urandom_range(99) < 15)
			repeat ($urandom_range(1, 3)) queue_word(8'($urandom_range(255)), 1'b0);
	endtask

	// Sends every queued word; returns in the cycle that accepted the last one.
	task automatic drive_words();
		word_row_t row;
		result_t   res;
		bit        produced;
		while (word_queue.size() != 0) begin
			row = word_queue.pop_front();
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			rx_byte <= row.data;
			start_of_packet <= row.sop;
			do @(posedge clk); while (in_ready !== 1'b1);
			produced = deframe_step(row.data, row.sop, res);
			if (row.typed)
				pending_results.push_back(row.want);
			else if (produced)
				pending_results.push_back(res);
		end
	endtask

	initial begin
		int unsigned counted;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_directed_rows();
		drive_words();
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_plan[p];
			stall_pct = stall_plan[p];
			counted = 0;
			while (counted < ItemsPerPhase)
				add_random_packet(counted);
			drive_words();
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready) begin
			got_res = '{kind: kind_t'(result_kind), index: param_index, pbyte: param_byte,
				ident: packet_ident, confirm: confirm_value, length: length_field,
				ok: checksum_ok};
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= ReportLimit)
					$display("unexpected result: kind=%0d index=%0d byte=%h ident=%h",
						got_res.kind, got_res.index, got_res.pbyte, got_res.ident);
			end else begin
				want_res = pending_results.pop_front();
				if (got_res.kind !== want_res.kind || got_res.index !== want_res.index ||
						got_res.pbyte !== want_res.pbyte || got_res.ident !== want_res.ident ||
						got_res.confirm !== want_res.confirm ||
						got_res.length !== want_res.length || got_res.ok !== want_res.ok) begin
					mismatch_count++;
					if (mismatch_count <= ReportLimit) begin
						$display(
							"expected: kind=%0d idx=%0d byte=%h id=%h conf=%h len=%h ok=%0d",
							want_res.kind, want_res.index, want_res.pbyte, want_res.ident,
							want_res.confirm, want_res.length, want_res.ok);
						$display(
							"actual:   kind=%0d idx=%0d byte=%h id=%h conf=%h len=%h ok=%0d",
							got_res.kind, got_res.index, got_res.pbyte, got_res.ident,
							got_res.confirm, got_res.length, got_res.ok);
					end
				end
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Cycles without any word moving on either side.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		while (!(stim_done && pending_results.size() == 0) && stuck_cycles < StuckLimit)
			@(posedge clk);
		timed_out = (stuck_cycles >= StuckLimit);
		if (!timed_out)
			repeat (TailCycles) @(posedge clk);
		if (!timed_out && mismatch_count == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
